@@ rtl/ipv6_ptf_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv6_ptf_pkg
// Shared types and constants for the IPv6 prefix text formatter and its checker.
// ----------------------------------------------------------------------------
package ipv6_ptf_pkg;

    localparam int unsigned ADDR_HALF_W = 64;
    localparam int unsigned LEN_W       = 8;
    localparam int unsigned CHAR_W      = 7;

    localparam logic [LEN_W-1:0] MAX_PREFIX_BITS = 8'd128;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2f;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OFFSET = 7'h57;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_PREFIX = 1'b1;

    typedef struct packed {
        logic [ADDR_HALF_W-1:0] address_high;
        logic [ADDR_HALF_W-1:0] address_low;
        logic [LEN_W-1:0]       prefix_length;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              status;
    } out_t;

    // lowercase hex digit to ascii
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10) begin
            r = CHAR_ZERO + {3'b000, d};
        end else begin
            r = HEX_ALPHA_OFFSET + {3'b000, d};
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] d);
        return CHAR_ZERO + {3'b000, d};
    endfunction

endpackage

@@ rtl/ipv6_prefix_text_formatter.sv @@
// ----------------------------------------------------------------------------
// ipv6_prefix_text_formatter
// Formats an IPv6 address and prefix length as compressed text, one ASCII
// character per output transaction.
// ----------------------------------------------------------------------------
//  channel | direction | ports                      | payload
//  --------+-----------+----------------------------+-------------------------
//  s_      | in        | s_valid, s_ready, s_data   | address halves, prefix
//  m_      | out       | m_valid, m_ready, m_data   | character, last, status
//
//  An item passes an accept step and a zero-run scan (one group per cycle
//  through a rotating shift register), then emits its characters, with a silent
//  separator step for the first group and a group right after "::", and groups
//  past two in a compressed run are skipped silently; a bad length gives an error.
//  aresetn is synchronous, active low, and clears the sequencer and output valid.
//  A waiting result stalls character cycles only; s_ready is high between items.
// ----------------------------------------------------------------------------
module ipv6_prefix_text_formatter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ipv6_ptf_pkg::in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ipv6_ptf_pkg::out_t  m_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_SEP  = 4'd2;
    localparam logic [3:0] ST_DIG  = 4'd3;
    localparam logic [3:0] ST_COL2 = 4'd4;
    localparam logic [3:0] ST_SKIP = 4'd5;
    localparam logic [3:0] ST_HUND = 4'd6;
    localparam logic [3:0] ST_TENS = 4'd7;
    localparam logic [3:0] ST_ONES = 4'd8;
    localparam logic [3:0] ST_ERR  = 4'd9;

    logic [3:0]   state_reg, state_next;
    logic [127:0] addr_reg, addr_next;
    logic [3:0]   grp_idx_reg, grp_idx_next;
    logic         run_on_reg, run_on_next;
    logic [2:0]   run_start_reg, run_start_next;
    logic [3:0]   run_len_reg, run_len_next;
    logic [2:0]   best_start_reg, best_start_next;
    logic [3:0]   best_len_reg, best_len_next;
    logic [3:0]   skip_reg, skip_next;
    logic         no_sep_reg, no_sep_next;
    logic [15:0]  digits_reg, digits_next;
    logic [1:0]   dcnt_reg, dcnt_next;
    logic         ge100_reg, ge100_next;
    logic         ge10_reg, ge10_next;
    logic [3:0]   tens_reg, tens_next;
    logic [3:0]   ones_reg, ones_next;
    logic         m_valid_reg, m_valid_next;
    ipv6_ptf_pkg::out_t m_data_reg, m_data_next;

    logic         step;
    logic         emit;
    ipv6_ptf_pkg::out_t emit_data;
    logic [15:0]  cur_grp;
    logic [1:0]   lz;
    logic [127:0] addr_shift;
    logic         compress;
    logic [3:0]   new_run_len;
    logic [2:0]   new_run_start;
    logic [7:0]   len_in;
    logic         in_ge100;
    logic [6:0]   rem_in;
    logic [14:0]  tens_prod;
    logic [3:0]   tens_in;
    logic [6:0]   tens_x10;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign step       = !m_valid_reg || m_ready;
    assign cur_grp    = addr_reg[127:112];
    assign addr_shift = {addr_reg[111:0], addr_reg[127:112]};
    assign compress   = (best_len_reg >= 4'd2);

    // leading zero nibbles of the current group, a zero group keeps one digit
    always_comb begin
        if (cur_grp[15:12] != 4'd0) begin
            lz = 2'd0;
        end else if (cur_grp[11:8] != 4'd0) begin
            lz = 2'd1;
        end else if (cur_grp[7:4] != 4'd0) begin
            lz = 2'd2;
        end else begin
            lz = 2'd3;
        end
    end

    assign new_run_len   = run_on_reg ? (run_len_reg + 4'd1) : 4'd1;
    assign new_run_start = run_on_reg ? run_start_reg : grp_idx_reg[2:0];

    // decimal split of the prefix length, divide by ten via reciprocal 205/2048
    assign len_in    = s_data.prefix_length;
    assign in_ge100  = (len_in >= 8'd100);
    assign rem_in    = in_ge100 ? 7'(len_in - 8'd100) : len_in[6:0];
    assign tens_prod = 15'(rem_in) * 15'd205;
    assign tens_in   = tens_prod[14:11];
    assign tens_x10  = 7'(tens_in) * 7'd10;

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        grp_idx_next    = grp_idx_reg;
        run_on_next     = run_on_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        skip_next       = skip_reg;
        no_sep_next     = no_sep_reg;
        digits_next     = digits_reg;
        dcnt_next       = dcnt_reg;
        ge100_next      = ge100_reg;
        ge10_next       = ge10_reg;
        tens_next       = tens_reg;
        ones_next       = ones_reg;
        emit            = 1'b0;
        emit_data.character = ipv6_ptf_pkg::CHAR_NUL;
        emit_data.last      = 1'b0;
        emit_data.status    = ipv6_ptf_pkg::STATUS_OK;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    addr_next      = {s_data.address_high, s_data.address_low};
                    grp_idx_next   = 4'd0;
                    run_on_next    = 1'b0;
                    run_len_next   = 4'd0;
                    run_start_next = 3'd0;
                    best_len_next  = 4'd0;
                    best_start_next = 3'd0;
                    no_sep_next    = 1'b1;
                    ge100_next     = in_ge100;
                    ge10_next      = (len_in >= 8'd10);
                    tens_next      = tens_in;
                    ones_next      = 4'(rem_in - tens_x10);
                    if (len_in > ipv6_ptf_pkg::MAX_PREFIX_BITS) begin
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cur_grp == 16'd0) begin
                    run_on_next    = 1'b1;
                    run_len_next   = new_run_len;
                    run_start_next = new_run_start;
                    if (new_run_len > best_len_reg) begin
                        best_len_next   = new_run_len;
                        best_start_next = new_run_start;
                    end
                end else begin
                    run_on_next  = 1'b0;
                    run_len_next = 4'd0;
                end
                addr_next = addr_shift;
                if (grp_idx_reg == 4'd7) begin
                    grp_idx_next = 4'd0;
                    state_next   = ST_SEP;
                end else begin
                    grp_idx_next = grp_idx_reg + 4'd1;
                end
            end
            ST_SEP: begin
                if (step) begin
                    if (grp_idx_reg == 4'd8) begin
                        emit = 1'b1;
                        emit_data.character = ipv6_ptf_pkg::CHAR_SLASH;
                        if (ge100_reg) begin
                            state_next = ST_HUND;
                        end else if (ge10_reg) begin
                            state_next = ST_TENS;
                        end else begin
                            state_next = ST_ONES;
                        end
                    end else if (compress && (grp_idx_reg[2:0] == best_start_reg)) begin
                        emit = 1'b1;
                        emit_data.character = ipv6_ptf_pkg::CHAR_COLON;
                        addr_next    = addr_shift;
                        grp_idx_next = grp_idx_reg + 4'd1;
                        skip_next    = best_len_reg - 4'd2;
                        state_next   = ST_COL2;
                    end else begin
                        if (!no_sep_reg) begin
                            emit = 1'b1;
                            emit_data.character = ipv6_ptf_pkg::CHAR_COLON;
                        end
                        digits_next  = cur_grp << {lz, 2'b00};
                        dcnt_next    = 2'd3 - lz;
                        addr_next    = addr_shift;
                        grp_idx_next = grp_idx_reg + 4'd1;
                        state_next   = ST_DIG;
                    end
                end
            end
            ST_DIG: begin
                if (step) begin
                    emit = 1'b1;
                    emit_data.character = ipv6_ptf_pkg::hex_char(digits_reg[15:12]);
                    digits_next = {digits_reg[11:0], 4'd0};
                    if (dcnt_reg == 2'd0) begin
                        no_sep_next = 1'b0;
                        state_next  = ST_SEP;
                    end else begin
                        dcnt_next = dcnt_reg - 2'd1;
                    end
                end
            end
            ST_COL2: begin
                if (step) begin
                    emit = 1'b1;
                    emit_data.character = ipv6_ptf_pkg::CHAR_COLON;
                    no_sep_next  = 1'b1;
                    addr_next    = addr_shift;
                    grp_idx_next = grp_idx_reg + 4'd1;
                    if (skip_reg == 4'd0) begin
                        state_next = ST_SEP;
                    end else begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                // groups inside the compressed run produce no text
                addr_next    = addr_shift;
                grp_idx_next = grp_idx_reg + 4'd1;
                skip_next    = skip_reg - 4'd1;
                if (skip_reg == 4'd1) begin
                    state_next = ST_SEP;
                end
            end
            ST_HUND: begin
                if (step) begin
                    emit = 1'b1;
                    emit_data.character = ipv6_ptf_pkg::dec_char(4'd1);
                    state_next = ST_TENS;
                end
            end
            ST_TENS: begin
                if (step) begin
                    emit = 1'b1;
                    emit_data.character = ipv6_ptf_pkg::dec_char(tens_reg);
                    state_next = ST_ONES;
                end
            end
            ST_ONES: begin
                if (step) begin
                    emit = 1'b1;
                    emit_data.character = ipv6_ptf_pkg::dec_char(ones_reg);
                    emit_data.last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (step) begin
                    emit = 1'b1;
                    emit_data.character = ipv6_ptf_pkg::CHAR_NUL;
                    emit_data.last      = 1'b1;
                    emit_data.status    = ipv6_ptf_pkg::STATUS_BAD_PREFIX;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        grp_idx_reg    <= grp_idx_next;
        run_on_reg     <= run_on_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        skip_reg       <= skip_next;
        no_sep_reg     <= no_sep_next;
        digits_reg     <= digits_next;
        dcnt_reg       <= dcnt_next;
        ge100_reg      <= ge100_next;
        ge10_reg       <= ge10_next;
        tens_reg       <= tens_next;
        ones_reg       <= ones_next;
        m_data_reg     <= m_data_next;
    end

endmodule

@@ rtl/ipv6_ptf_checker.sv @@
// ----------------------------------------------------------------------------
// ipv6_ptf_checker
// Port-level assertions for the IPv6 prefix text formatter.
// ----------------------------------------------------------------------------
module ipv6_ptf_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ipv6_ptf_pkg::in_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ipv6_ptf_pkg::out_t m_data
);

    // a stalled result transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result payload changed while stalled");

    // one item at a time: no new input right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous item in progress");

    // an error result is a lone nul character that closes the item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.last && (m_data.character == ipv6_ptf_pkg::CHAR_NUL)))
        else $error("error result malformed");

    // an out-of-range prefix length leaves no text behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.prefix_length > ipv6_ptf_pkg::MAX_PREFIX_BITS))
            |=> !(m_valid && !m_data.status && $past(!m_valid)))
        else $error("text produced for invalid prefix length");

endmodule

bind ipv6_prefix_text_formatter ipv6_ptf_checker u_ipv6_ptf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
